// ----- rtl/segment_box_time_clip_macros.svh -----
// Assertion macros shared by the segment box time clip RTL.
`ifndef SEGMENT_BOX_TIME_CLIP_MACROS_SVH
`define SEGMENT_BOX_TIME_CLIP_MACROS_SVH
`ifndef SYNTHESIS
`define SBTC_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SBTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SBTC_ASSERT(lbl, clk, rst, ante, cons)
`define SBTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/sbtc_pkg.sv -----
// Package: types and constants of the segment box time clip.
package sbtc_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int DiffWidth  = CoordWidth + 3;
   localparam int CsrIdxW    = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BOX_X_MIN   = 3'd0,
      CSR_BOX_X_MAX   = 3'd1,
      CSR_BOX_Y_MIN   = 3'd2,
      CSR_BOX_Y_MAX   = 3'd3,
      CSR_GROW_RADIUS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] start_x;
      logic signed [CoordWidth-1:0] start_y;
      logic signed [CoordWidth-1:0] end_x;
      logic signed [CoordWidth-1:0] end_y;
      logic signed [CoordWidth-1:0] start_time;
      logic signed [CoordWidth-1:0] end_time;
   } req_type;

   typedef struct packed {
      logic                         active;
      logic signed [CoordWidth-1:0] enter_at;
      logic signed [CoordWidth-1:0] leave_at;
   } rsp_type;

   // per-side flags that travel with the quotient
   typedef struct packed {
      logic p_zero;
      logic q_neg;
   } side_flag_type;

endpackage

// ----- rtl/sbtc_frac_div.sv -----
// Pipelined fraction divider: saturated q/p with one quotient bit per stage.
module sbtc_frac_div #(
   parameter int FRAC_BITS = sbtc_pkg::FracBits
) (
   input  logic                               clock,
   input  logic signed [sbtc_pkg::DiffWidth-1:0] p_in,
   input  logic signed [sbtc_pkg::DiffWidth-1:0] q_in,
   output logic signed [FRAC_BITS+2:0]        u_out,
   output sbtc_pkg::side_flag_type            flag_out
);
   localparam int DW = sbtc_pkg::DiffWidth;
   localparam int RW = DW + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam int NS = FRAC_BITS + 2;

   logic [DW-1:0] ap_ff  [NS];
   logic [RW-1:0] r_ff   [NS];
   logic [QW-1:0] quo_ff [NS];
   logic          neg_ff [NS];
   logic          sat_ff [NS];
   sbtc_pkg::side_flag_type flag_ff [NS];

   logic [DW-1:0] aq_in, ap_in;
   logic [FRAC_BITS+1:0] mag;

   // take magnitudes and flag quotients of two or more
   always_comb begin
      aq_in = q_in[DW-1] ? DW'(-q_in) : DW'(q_in);
      ap_in = p_in[DW-1] ? DW'(-p_in) : DW'(p_in);
   end

   always_ff @(posedge clock) begin
      ap_ff[0]          <= ap_in;
      r_ff[0]           <= {1'b0, aq_in};
      quo_ff[0]         <= '0;
      neg_ff[0]         <= q_in[DW-1] != p_in[DW-1];
      sat_ff[0]         <= {1'b0, aq_in} >= {ap_in, 1'b0};
      flag_ff[0].p_zero <= p_in == '0;
      flag_ff[0].q_neg  <= q_in[DW-1];
   end

   // restoring steps: integer bit first, then the fraction bits
   for (genvar k = 0; k < NS - 1; k++) begin : g_step
      logic [RW-1:0] rr;
      logic          ge;
      always_comb begin
         if (k == 0) begin
            rr = r_ff[k];
         end else begin
            rr = {r_ff[k][RW-2:0], 1'b0};
         end
         ge = rr >= {1'b0, ap_ff[k]};
      end
      always_ff @(posedge clock) begin
         ap_ff[k+1]   <= ap_ff[k];
         r_ff[k+1]    <= ge ? (rr - {1'b0, ap_ff[k]}) : rr;
         quo_ff[k+1]  <= {quo_ff[k][QW-2:0], ge};
         neg_ff[k+1]  <= neg_ff[k];
         sat_ff[k+1]  <= sat_ff[k];
         flag_ff[k+1] <= flag_ff[k];
      end
   end

   // saturate at two and apply the sign
   always_comb begin
      mag   = sat_ff[NS-1] ? (FRAC_BITS+2)'(1) << (FRAC_BITS + 1)
                           : {1'b0, quo_ff[NS-1]};
      u_out = neg_ff[NS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      flag_out = flag_ff[NS-1];
   end

endmodule

// ----- rtl/sbtc_clip_eval.sv -----
// Clip evaluation: run the four side tests in order and register the interval.
module sbtc_clip_eval #(
   parameter int FRAC_BITS = sbtc_pkg::FracBits
) (
   input  logic                        clock,
   input  logic signed [FRAC_BITS+2:0] u_in     [4],
   input  sbtc_pkg::side_flag_type     flag_in  [4],
   input  logic                        p_neg_in [4],
   output logic                        ok_out,
   output logic        [FRAC_BITS:0]   lo_out,
   output logic        [FRAC_BITS:0]   hi_out
);
   localparam int UW = FRAC_BITS + 3;

   logic signed [UW-1:0] lo, hi;
   logic                 ok_in;
   logic [FRAC_BITS:0]   lo_in, hi_in;
   logic                 ok_ff;
   logic [FRAC_BITS:0]   lo_ff, hi_ff;

   // narrow [lo,hi]: a side with negative p raises lo, one with positive p lowers hi
   always_comb begin
      lo    = '0;
      hi    = UW'(1) <<< FRAC_BITS;
      ok_in = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (ok_in) begin
            if (flag_in[i].p_zero) begin
               // parallel to this side: drop the segment when it starts outside
               if (flag_in[i].q_neg) ok_in = 1'b0;
            end else if (p_neg_in[i]) begin
               if (u_in[i] > hi) ok_in = 1'b0;
               else if (u_in[i] > lo) lo = u_in[i];
            end else begin
               if (u_in[i] < lo) ok_in = 1'b0;
               else if (u_in[i] < hi) hi = u_in[i];
            end
         end
      end
      if (hi < lo) ok_in = 1'b0;
      lo_in = lo[FRAC_BITS:0];
      hi_in = hi[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign ok_out = ok_ff;
   assign lo_out = lo_ff;
   assign hi_out = hi_ff;

endmodule

// ----- rtl/segment_box_time_clip.sv -----
// Top level: segment box time clip.
// Register order: input registers, divider stages, clip evaluation, duration scaling, then the result register.
// Throughput: one transaction per cycle; the long path is the divider's bit-per-stage line.
// busy stays low; rsp_valid is a one-cycle strobe and cannot be held off.
// Synchronous active-high reset clears valid bits, the box registers and the grow radius to zero.
module segment_box_time_clip #(
   parameter int FRAC_BITS = sbtc_pkg::FracBits
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sbtc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output sbtc_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [sbtc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [sbtc_pkg::CoordWidth-1:0] csr_wdata
);
`include "segment_box_time_clip_macros.svh"
   localparam int CW = sbtc_pkg::CoordWidth;
   localparam int DW = sbtc_pkg::DiffWidth;
   localparam int UW = FRAC_BITS + 3;
   localparam int DL = FRAC_BITS + 2;
   localparam int PW = FRAC_BITS + 1 + CW;

   logic [CW-1:0] box_xmin_ff, box_xmax_ff, box_ymin_ff, box_ymax_ff;
   logic [CW-2:0] grow_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         box_xmin_ff <= '0;
         box_xmax_ff <= '0;
         box_ymin_ff <= '0;
         box_ymax_ff <= '0;
         grow_ff     <= '0;
      end else if (csr_we) begin
         case (sbtc_pkg::csr_index_type'(csr_index))
            sbtc_pkg::CSR_BOX_X_MIN:   box_xmin_ff <= csr_wdata;
            sbtc_pkg::CSR_BOX_X_MAX:   box_xmax_ff <= csr_wdata;
            sbtc_pkg::CSR_BOX_Y_MIN:   box_ymin_ff <= csr_wdata;
            sbtc_pkg::CSR_BOX_Y_MAX:   box_ymax_ff <= csr_wdata;
            sbtc_pkg::CSR_GROW_RADIUS: grow_ff     <= csr_wdata[CW-2:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start & ~busy;

   // front end: grown bounds, side directions and distances, duration
   logic signed [DW-1:0] g, xlo, xhi, ylo, yhi, x0, y0, x1, y1;
   logic signed [DW-1:0] p_in [4];
   logic signed [DW-1:0] q_in [4];
   logic signed [CW:0]   dts;
   logic [CW-1:0]        dt_in;

   always_comb begin
      g   = $signed({{(DW-CW+1){1'b0}}, grow_ff});
      xlo = $signed({{(DW-CW){box_xmin_ff[CW-1]}}, box_xmin_ff}) - g;
      xhi = $signed({{(DW-CW){box_xmax_ff[CW-1]}}, box_xmax_ff}) + g;
      ylo = $signed({{(DW-CW){box_ymin_ff[CW-1]}}, box_ymin_ff}) - g;
      yhi = $signed({{(DW-CW){box_ymax_ff[CW-1]}}, box_ymax_ff}) + g;
      x0  = DW'(req_data.start_x);
      y0  = DW'(req_data.start_y);
      x1  = DW'(req_data.end_x);
      y1  = DW'(req_data.end_y);
      p_in[0] = x0 - x1;  q_in[0] = x0 - xlo;
      p_in[1] = x1 - x0;  q_in[1] = xhi - x0;
      p_in[2] = y0 - y1;  q_in[2] = y0 - ylo;
      p_in[3] = y1 - y0;  q_in[3] = yhi - y0;
      dts   = (CW+1)'(req_data.end_time) - (CW+1)'(req_data.start_time);
      dt_in = dts[CW] ? '0 : dts[CW-1:0];
   end

   logic signed [DW-1:0] p_ff [4];
   logic signed [DW-1:0] q_ff [4];
   logic                 vld_ff [DL+1];
   logic [CW-1:0]        t0_ff  [DL+1];
   logic [CW-1:0]        dt_ff  [DL+1];
   logic                 pneg_ff [DL+1][4];

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      q_ff  <= q_in;
      t0_ff[0] <= req_data.start_time;
      dt_ff[0] <= dt_in;
      for (int i = 0; i < 4; i++) pneg_ff[0][i] <= p_in[i][DW-1];
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= accept;
   end

   // sideband line alongside the dividers
   for (genvar s = 0; s < DL; s++) begin : g_side
      always_ff @(posedge clock) begin
         t0_ff[s+1]   <= t0_ff[s];
         dt_ff[s+1]   <= dt_ff[s];
         pneg_ff[s+1] <= pneg_ff[s];
         if (reset) vld_ff[s+1] <= 1'b0;
         else       vld_ff[s+1] <= vld_ff[s];
      end
   end

   logic signed [UW-1:0]    u_d [4];
   sbtc_pkg::side_flag_type f_d [4];

   for (genvar i = 0; i < 4; i++) begin : g_div
      sbtc_frac_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .p_in    (p_ff[i]),
         .q_in    (q_ff[i]),
         .u_out   (u_d[i]),
         .flag_out(f_d[i])
      );
   end

   // side tests in order, with the sign of p from the sideband
   logic               ev_ok;
   logic [FRAC_BITS:0] ev_lo, ev_hi;

   sbtc_clip_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clock   (clock),
      .u_in    (u_d),
      .flag_in (f_d),
      .p_neg_in(pneg_ff[DL]),
      .ok_out  (ev_ok),
      .lo_out  (ev_lo),
      .hi_out  (ev_hi)
   );

   logic          ev_vld_ff;
   logic [CW-1:0] ev_t0_ff, ev_dt_ff;

   always_ff @(posedge clock) begin
      ev_t0_ff <= t0_ff[DL];
      ev_dt_ff <= dt_ff[DL];
      if (reset) ev_vld_ff <= 1'b0;
      else       ev_vld_ff <= vld_ff[DL];
   end

   // scale both fractions by the duration
   logic          mu_vld_ff, mu_ok_ff;
   logic [PW-1:0] mu_lo_ff, mu_hi_ff;
   logic [CW-1:0] mu_t0_ff;

   always_ff @(posedge clock) begin
      mu_ok_ff <= ev_ok;
      mu_lo_ff <= PW'(ev_lo) * PW'(ev_dt_ff);
      mu_hi_ff <= PW'(ev_hi) * PW'(ev_dt_ff);
      mu_t0_ff <= ev_t0_ff;
      if (reset) mu_vld_ff <= 1'b0;
      else       mu_vld_ff <= ev_vld_ff;
   end

   // add the start time and drive the result strobe
   logic signed [CW:0] enter_s, leave_s;
   logic               act;
   always_comb begin
      enter_s = (CW+1)'($signed(mu_t0_ff)) + $signed({1'b0, mu_lo_ff[FRAC_BITS +: CW]});
      leave_s = (CW+1)'($signed(mu_t0_ff)) + $signed({1'b0, mu_hi_ff[FRAC_BITS +: CW]});
      act     = mu_ok_ff & ~(leave_s < enter_s);
   end

   logic              rsp_valid_ff;
   sbtc_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.active   <= act;
      rsp_ff.enter_at <= act ? enter_s[CW-1:0] : '0;
      rsp_ff.leave_at <= act ? leave_s[CW-1:0] : '0;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= mu_vld_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SBTC_ASSERT(a_inactive_zero, clock, reset, rsp_valid && !rsp_data.active, rsp_data.enter_at == '0 && rsp_data.leave_at == '0)
   `SBTC_ASSERT(a_active_order, clock, reset, rsp_valid && rsp_data.active, rsp_data.enter_at <= rsp_data.leave_at)
   `SBTC_ASSERT(a_ok_interval, clock, reset, ev_vld_ff && ev_ok, ev_lo <= ev_hi && ev_hi <= (FRAC_BITS+1)'(1) << FRAC_BITS)

endmodule
